### rtl/tskf_pkg.sv
`default_nettype none
package tskf_pkg;

    localparam int REM_W = 67;
    localparam int CNT_W = 6;
    localparam int QUOT_W = 32;

    typedef enum logic [2:0] {
        REG_PROCESS_NOISE = 3'd0,
        REG_FIRST_NOISE   = 3'd1,
        REG_SECOND_NOISE  = 3'd2,
        REG_SAMPLE_SCALE  = 3'd3,
        REG_START_VAR     = 3'd4
    } reg_idx_t;

    localparam logic [31:0] RST_PROCESS_NOISE = 32'd120;
    localparam logic [31:0] RST_SENSOR_NOISE  = 32'd120;
    localparam logic [15:0] RST_SAMPLE_SCALE  = 16'd1;
    localparam logic [31:0] RST_START_VAR     = 32'd10;
    localparam logic [31:0] RST_VARIANCE      = 32'd10;

    typedef struct packed {
        logic             start;
        logic             no_shift_first;
        logic [CNT_W-1:0] steps;
    } div_req_t;

endpackage
`default_nettype wire

### rtl/tskf_mul.sv
`default_nettype none
module tskf_mul import tskf_pkg::*; (
    input  wire logic        aclk,
    input  wire logic [31:0] op_a,
    input  wire logic [31:0] op_b,
    output logic      [63:0] prod
);

    logic [63:0] prod_reg;

    always_ff @(posedge aclk) begin
        prod_reg <= 64'(op_a) * 64'(op_b);
    end

    assign prod = prod_reg;

endmodule
`default_nettype wire

### rtl/tskf_div.sv
`default_nettype none
module tskf_div import tskf_pkg::*; (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire div_req_t          req,
    input  wire logic [REM_W-1:0]  rem_init,
    input  wire logic [REM_W-1:0]  den,
    input  wire logic [31:0]       dividend,
    output logic      [QUOT_W-1:0] quot,
    output logic                   done
);

    logic             busy_reg;
    logic             done_reg;
    logic             first_reg;
    logic             no_shift_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [REM_W-1:0] rem_reg;
    logic [REM_W-1:0] den_reg;
    logic [31:0]      dvd_reg;
    logic [QUOT_W-1:0] q_reg;

    logic             shift;
    logic [REM_W-1:0] trial;
    logic             ge;
    logic [REM_W-1:0] rem_next;

    always_comb begin
        shift    = !(first_reg && no_shift_reg);
        trial    = shift ? {rem_reg[REM_W-2:0], dvd_reg[31]} : rem_reg;
        ge       = (trial >= den_reg);
        rem_next = ge ? (trial - den_reg) : trial;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start && !busy_reg) begin
                busy_reg <= 1'b1;
                cnt_reg  <= req.steps;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start && !busy_reg) begin
            rem_reg      <= rem_init;
            den_reg      <= den;
            dvd_reg      <= dividend;
            q_reg        <= '0;
            first_reg    <= 1'b1;
            no_shift_reg <= req.no_shift_first;
        end else if (busy_reg) begin
            rem_reg   <= rem_next;
            q_reg     <= {q_reg[QUOT_W-2:0], ge};
            first_reg <= 1'b0;
            if (shift) begin
                dvd_reg <= {dvd_reg[30:0], 1'b0};
            end
        end
    end

    assign quot = q_reg;
    assign done = done_reg;

endmodule
`default_nettype wire

### rtl/two_sensor_kalman_fusion.sv
// Channel  Direction  Ports                 Contents
// s_       in         tvalid/tready/tdata   sensor_a, sensor_b; tuser = opcode
// m_       out        tvalid/tready/tdata   filtered_value, current_variance
// apb      in         psel..prdata          five registers at 4*i (scale 16-bit)
//
// A shared restoring divider, one quotient bit per cycle, is run for both gains
// and for the output scaling; a shared multiplier serves every product.
// Reset is synchronous and active low; no clearing pass is needed.
// A waiting result does not block intake; a stalled result stalls only the final step.
`default_nettype none
module two_sensor_kalman_fusion import tskf_pkg::*; #(
    parameter int GAIN_FRACTION_BITS = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,  // sensor_a [15:0], sensor_b [31:16]
    input  wire logic        s_tuser,  // opcode [0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [47:0] m_tdata,  // filtered_value [15:0], current_variance [47:16]
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);

    localparam int F = GAIN_FRACTION_BITS;
    localparam int GW = F + 1;
    localparam int ACC_W = F + 34;
    localparam logic [GW-1:0] FULL = GW'(1) << F;
    localparam logic [GW-1:0] HALF = GW'(1) << (F - 1);

    typedef enum logic [4:0] {
        S_IDLE, S_SA, S_SB, S_PRED, S_PR1, S_PR2, S_R1R2, S_SUMD, S_G1, S_G1W, S_G2W,
        S_W, S_XW, S_G1SA, S_G2SB, S_ACC, S_PW, S_VAR, S_OSTART, S_OUTW, S_OUT
    } state_t;

    state_t      state_reg;
    logic [31:0] pnoise_reg, r1_reg, r2_reg, svar_reg;
    logic [15:0] scale_reg;
    logic        op_reg;
    logic [15:0] a_reg, b_reg;
    logic [31:0] sa_reg, sb_reg, est_reg, var_reg, p_reg;
    logic [63:0] pr1_reg, pr2_reg;
    logic [65:0] den_reg;
    logic [GW-1:0] g1_reg, g2_reg, w_reg;
    logic [ACC_W-1:0] acc_reg;
    logic [15:0] fv_reg;
    logic        m_tvalid_reg;
    logic [47:0] m_tdata_reg;

    logic [15:0] scale_eff;
    logic [31:0] mul_a, mul_b;
    logic [63:0] prod;
    logic [32:0] p_sum;
    div_req_t    div_req;
    logic [REM_W-1:0] div_rem, div_den;
    logic [31:0] div_dvd;
    logic [QUOT_W-1:0] quot;
    logic        div_done;
    logic        cfg_wr;
    reg_idx_t    cfg_idx;

    assign scale_eff = (scale_reg == 16'd0) ? 16'd1 : scale_reg;
    assign p_sum = {1'b0, var_reg} + {1'b0, pnoise_reg};
    assign cfg_wr = psel && penable && pwrite;
    assign cfg_idx = reg_idx_t'(paddr[4:2]);
    assign pready = 1'b1;
    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata = m_tdata_reg;

    always_comb begin
        unique case (cfg_idx)
            REG_PROCESS_NOISE: prdata = pnoise_reg;
            REG_FIRST_NOISE:   prdata = r1_reg;
            REG_SECOND_NOISE:  prdata = r2_reg;
            REG_SAMPLE_SCALE:  prdata = {16'd0, scale_reg};
            REG_START_VAR:     prdata = svar_reg;
            default:           prdata = 32'd0;
        endcase
    end

    always_comb begin
        unique case (state_reg)
            S_SA:    begin mul_a = {16'd0, a_reg};  mul_b = {16'd0, scale_eff}; end
            S_SB:    begin mul_a = {16'd0, b_reg};  mul_b = {16'd0, scale_eff}; end
            S_PR1:   begin mul_a = p_reg;           mul_b = r1_reg;             end
            S_PR2:   begin mul_a = p_reg;           mul_b = r2_reg;             end
            S_R1R2:  begin mul_a = r1_reg;          mul_b = r2_reg;             end
            S_XW:    begin mul_a = est_reg;         mul_b = 32'(w_reg);         end
            S_G1SA:  begin mul_a = 32'(g1_reg);     mul_b = sa_reg;             end
            S_G2SB:  begin mul_a = 32'(g2_reg);     mul_b = sb_reg;             end
            S_PW:    begin mul_a = p_reg;           mul_b = 32'(w_reg);         end
            default: begin mul_a = 32'd0;           mul_b = 32'd0;              end
        endcase
    end

    always_comb begin
        div_req.start          = 1'b0;
        div_req.no_shift_first = 1'b1;
        div_req.steps          = CNT_W'(GW);
        div_rem                = REM_W'(pr2_reg);
        div_den                = REM_W'(den_reg);
        div_dvd                = 32'd0;
        if (state_reg == S_G1) begin
            div_req.start = (den_reg != 66'd0);
        end else if (state_reg == S_G1W) begin
            div_req.start = div_done;
            div_rem       = REM_W'(pr1_reg);
        end else if (state_reg == S_OSTART) begin
            div_req.start          = 1'b1;
            div_req.no_shift_first = 1'b0;
            div_req.steps          = CNT_W'(QUOT_W);
            div_rem                = '0;
            div_den                = REM_W'(scale_eff);
            div_dvd                = est_reg;
        end
    end

    tskf_mul u_mul (
        .aclk (aclk),
        .op_a (mul_a),
        .op_b (mul_b),
        .prod (prod)
    );

    tskf_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .req      (div_req),
        .rem_init (div_rem),
        .den      (div_den),
        .dividend (div_dvd),
        .quot     (quot),
        .done     (div_done)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            m_tvalid_reg <= 1'b0;
            pnoise_reg   <= RST_PROCESS_NOISE;
            r1_reg       <= RST_SENSOR_NOISE;
            r2_reg       <= RST_SENSOR_NOISE;
            scale_reg    <= RST_SAMPLE_SCALE;
            svar_reg     <= RST_START_VAR;
            est_reg      <= 32'd0;
            var_reg      <= RST_VARIANCE;
        end else begin
            if (m_tvalid_reg && m_tready && state_reg != S_OUT) begin
                m_tvalid_reg <= 1'b0;
            end
            if (cfg_wr) begin
                unique case (cfg_idx)
                    REG_PROCESS_NOISE: pnoise_reg <= pwdata;
                    REG_FIRST_NOISE:   r1_reg     <= pwdata;
                    REG_SECOND_NOISE:  r2_reg     <= pwdata;
                    REG_SAMPLE_SCALE:  scale_reg  <= pwdata[15:0];
                    REG_START_VAR:     svar_reg   <= pwdata;
                    default:           ;
                endcase
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (s_tvalid) begin
                        op_reg    <= s_tuser;
                        a_reg     <= s_tdata[15:0];
                        b_reg     <= s_tdata[31:16];
                        state_reg <= S_SA;
                    end
                end
                S_SA: state_reg <= S_SB;
                S_SB: begin
                    sa_reg    <= prod[31:0];
                    state_reg <= S_PRED;
                end
                S_PRED: begin
                    if (op_reg) begin
                        est_reg   <= 32'(({1'b0, sa_reg} + {1'b0, prod[31:0]}) >> 1);
                        var_reg   <= svar_reg;
                        state_reg <= S_OSTART;
                    end else begin
                        sb_reg    <= prod[31:0];
                        p_reg     <= p_sum[32] ? 32'hFFFF_FFFF : p_sum[31:0];
                        state_reg <= S_PR1;
                    end
                end
                S_PR1: state_reg <= S_PR2;
                S_PR2: begin
                    pr1_reg   <= prod;
                    state_reg <= S_R1R2;
                end
                S_R1R2: begin
                    pr2_reg   <= prod;
                    den_reg   <= 66'(pr1_reg) + 66'(prod);
                    state_reg <= S_SUMD;
                end
                S_SUMD: begin
                    den_reg   <= den_reg + 66'(prod);
                    state_reg <= S_G1;
                end
                S_G1: begin
                    if (den_reg == 66'd0) begin
                        g1_reg    <= (p_reg != 32'd0) ? HALF : '0;
                        g2_reg    <= (p_reg != 32'd0) ? HALF : '0;
                        state_reg <= S_W;
                    end else begin
                        state_reg <= S_G1W;
                    end
                end
                S_G1W: begin
                    if (div_done) begin
                        g1_reg    <= quot[GW-1:0];
                        state_reg <= S_G2W;
                    end
                end
                S_G2W: begin
                    if (div_done) begin
                        g2_reg    <= quot[GW-1:0];
                        state_reg <= S_W;
                    end
                end
                S_W: begin
                    w_reg     <= FULL - g1_reg - g2_reg;
                    state_reg <= S_XW;
                end
                S_XW: state_reg <= S_G1SA;
                S_G1SA: begin
                    acc_reg   <= prod[ACC_W-1:0] + ACC_W'(HALF);
                    state_reg <= S_G2SB;
                end
                S_G2SB: begin
                    acc_reg   <= acc_reg + prod[ACC_W-1:0];
                    state_reg <= S_ACC;
                end
                S_ACC: begin
                    acc_reg   <= acc_reg + prod[ACC_W-1:0];
                    state_reg <= S_PW;
                end
                S_PW: begin
                    est_reg   <= acc_reg[F+31:F];
                    state_reg <= S_VAR;
                end
                S_VAR: begin
                    var_reg   <= prod[F+31:F];
                    state_reg <= S_OSTART;
                end
                S_OSTART: state_reg <= S_OUTW;
                S_OUTW: begin
                    if (div_done) begin
                        fv_reg    <= (quot[31:16] != 16'd0) ? 16'hFFFF : quot[15:0];
                        state_reg <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!m_tvalid_reg || m_tready) begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= {var_reg, fv_reg};
                        state_reg    <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    a_done_state: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> (state_reg == S_G1W || state_reg == S_G2W || state_reg == S_OUTW))
        else $error("divider finished outside a wait state");

    a_accept_next: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> state_reg == S_SA)
        else $error("accepted word did not start the sequence");

    a_gain_sum: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_W |-> ({1'b0, g1_reg} + {1'b0, g2_reg}) <= {1'b0, FULL})
        else $error("gain sum exceeds unity");

    a_out_origin: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(state_reg) == S_OUT)
        else $error("result raised outside the output step");

endmodule
`default_nettype wire

### tb/tb_two_sensor_kalman_fusion.sv
`default_nettype none
module tb_two_sensor_kalman_fusion;
    timeunit 1ns;
    timeprecision 1ps;
    import tskf_pkg::*;

    localparam int FRAC = 16;
    localparam int ITEMS = 1500;
    localparam longint CYCLE_LIMIT = 2000000;

    typedef struct {
        logic        reload;
        logic [15:0] sensor_a;
        logic [15:0] sensor_b;
    } sample_t;

    typedef struct {
        logic [15:0] filtered_value;
        logic [31:0] current_variance;
    } fused_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    two_sensor_kalman_fusion dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // Predictor state and register copies.
    logic [31:0] q_noise, r1_noise, r2_noise, start_var, est_scaled, est_var;
    logic [15:0] scale_reg;

    sample_t pending_words[$];
    fused_t  expected_fusions[$];
    int      errors = 0;
    int      words_sent = 0;
    int      words_checked = 0;
    int      reloads_sent = 0;
    longint  cycles = 0;
    bit      long_hold = 0;
    bit      taken = 0;

    always begin
        aclk = 1'b1;
        #10;
        aclk = 1'b0;
        #10;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    function automatic logic [31:0] gain_quotient(logic [66:0] num, logic [66:0] den);
        logic [66:0] rem;
        logic [31:0] q;
        rem = num;
        q = 0;
        if (rem >= den) begin
            rem = rem - den;
            q = 1;
        end
        for (int i = 0; i < FRAC; i++) begin
            rem = rem << 1;
            q = q << 1;
            if (rem >= den) begin
                rem = rem - den;
                q[0] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic fused_t fuse_sample(sample_t s);
        logic [63:0] scl, sa, sb, p, g1, g2, w, full;
        logic [66:0] den;
        logic [95:0] acc;
        logic [63:0] q;
        fused_t r;
        scl = (scale_reg == 0) ? 64'd1 : 64'(scale_reg);
        sa = 64'(s.sensor_a) * scl;
        sb = 64'(s.sensor_b) * scl;
        full = 64'd1 << FRAC;
        if (s.reload) begin
            est_scaled = 32'((sa + sb) >> 1);
            est_var = start_var;
        end else begin
            p = 64'(est_var) + 64'(q_noise);
            if (p > 64'hFFFF_FFFF) p = 64'hFFFF_FFFF;
            den = 67'(p * 64'(r1_noise)) + 67'(p * 64'(r2_noise))
                + 67'(64'(r1_noise) * 64'(r2_noise));
            if (den == 0) begin
                g1 = (p != 0) ? full >> 1 : 0;
                g2 = g1;
            end else begin
                g1 = 64'(gain_quotient(67'(p * 64'(r2_noise)), den));
                g2 = 64'(gain_quotient(67'(p * 64'(r1_noise)), den));
            end
            w = full - g1 - g2;
            acc = 96'(est_scaled) * 96'(w) + 96'(g1 * sa) + 96'(g2 * sb) + 96'(full >> 1);
            est_scaled = 32'(acc >> FRAC);
            est_var = 32'((p * w) >> FRAC);
        end
        q = 64'(est_scaled) / scl;
        r.filtered_value = (q > 64'hFFFF) ? 16'hFFFF : q[15:0];
        r.current_variance = est_var;
        return r;
    endfunction

    // Accepted words are predicted at the rising edge where they are taken.
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) begin
            expected_fusions.push_back(fuse_sample(pending_words.pop_front()));
            words_sent <= words_sent + 1;
            taken = 1'b1;
        end
    end

    // Driver: bursts of back-to-back words with random gaps.
    int gap_left = 0;
    int burst_left = 0;
    always @(negedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && !taken) begin
                // Hold the current word.
            end else if (pending_words.size() == 0) begin
                s_tvalid <= 1'b0;
            end else if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                s_tvalid <= 1'b0;
            end else begin
                s_tvalid <= 1'b1;
                s_tdata <= {pending_words[0].sensor_b, pending_words[0].sensor_a};
                s_tuser <= pending_words[0].reload;
                if (burst_left > 0) begin
                    burst_left <= burst_left - 1;
                end else begin
                    burst_left <= $urandom_range(0, 8);
                    gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 60);
                end
            end
            taken = 1'b0;
        end
    end

    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (long_hold) begin
            m_tready <= 1'b0;
        end else begin
            case ($urandom_range(0, 3))
                0: m_tready <= 1'b0;
                default: m_tready <= 1'b1;
            endcase
        end
    end

    // Monitor.
    always @(posedge aclk) begin
        fused_t exp_w;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_fusions.size() == 0) begin
                $error("unexpected word: filtered_value %0d current_variance %0d",
                       m_tdata[15:0], m_tdata[47:16]);
                errors++;
            end else begin
                exp_w = expected_fusions.pop_front();
                words_checked++;
                if (m_tdata[15:0] !== exp_w.filtered_value) begin
                    $error("filtered_value expected %0d actual %0d",
                           exp_w.filtered_value, m_tdata[15:0]);
                    errors++;
                end
                if (m_tdata[47:16] !== exp_w.current_variance) begin
                    $error("current_variance expected %0d actual %0d",
                           exp_w.current_variance, m_tdata[47:16]);
                    errors++;
                end
            end
        end
    end

    task automatic write_reg(reg_idx_t idx, logic [31:0] value);
        @(negedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= 5'(idx) << 2;
        pwdata <= value;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        case (idx)
            REG_PROCESS_NOISE: q_noise = value;
            REG_FIRST_NOISE:   r1_noise = value;
            REG_SECOND_NOISE:  r2_noise = value;
            REG_SAMPLE_SCALE:  scale_reg = value[15:0];
            REG_START_VAR:     start_var = value;
            default: ;
        endcase
        @(negedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic drain();
        while (pending_words.size() != 0 || s_tvalid || expected_fusions.size() != 0)
            @(posedge aclk);
        repeat (200) @(posedge aclk);
    endtask

    task automatic queue_word(logic reload, logic [15:0] a, logic [15:0] b);
        sample_t s;
        s.reload = reload;
        s.sensor_a = a;
        s.sensor_b = b;
        pending_words.push_back(s);
        if (reload) reloads_sent++;
    endtask

    task automatic queue_random(int n);
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(0, 5))
                0: queue_word($urandom_range(0, 9) == 0, 16'hFFFF, 16'hFFFF);
                1: queue_word($urandom_range(0, 9) == 0, 16'(0), 16'($urandom));
                default: queue_word($urandom_range(0, 9) == 0, 16'($urandom), 16'($urandom));
            endcase
        end
    endtask

    task automatic random_noise_regs();
        write_reg(REG_PROCESS_NOISE,
                  ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 5000));
        write_reg(REG_FIRST_NOISE,
                  ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 5000));
        write_reg(REG_SECOND_NOISE,
                  ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 5000));
        write_reg(REG_START_VAR, $urandom);
        write_reg(REG_SAMPLE_SCALE,
                  ($urandom_range(0, 1) == 0) ? $urandom_range(1, 8) : $urandom_range(0, 65535));
    endtask

    initial begin
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        q_noise = RST_PROCESS_NOISE;
        r1_noise = RST_SENSOR_NOISE;
        r2_noise = RST_SENSOR_NOISE;
        scale_reg = RST_SAMPLE_SCALE;
        start_var = RST_START_VAR;
        est_scaled = 0;
        est_var = RST_VARIANCE;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed words under reset settings.
        queue_word(1'b0, 16'd0, 16'd0);
        queue_word(1'b0, 16'hFFFF, 16'hFFFF);
        queue_word(1'b1, 16'hFFFF, 16'h0000);
        queue_word(1'b0, 16'h0000, 16'hFFFF);
        queue_word(1'b1, 16'hAAAA, 16'h5555);
        queue_word(1'b0, 16'h5555, 16'hAAAA);
        drain();

        // Both sensor noises zero, then zero prediction variance too.
        write_reg(REG_FIRST_NOISE, 32'd0);
        write_reg(REG_SECOND_NOISE, 32'd0);
        queue_word(1'b0, 16'd1000, 16'd3000);
        drain();
        write_reg(REG_PROCESS_NOISE, 32'd0);
        write_reg(REG_START_VAR, 32'd0);
        queue_word(1'b1, 16'd400, 16'd600);
        queue_word(1'b0, 16'hFFFF, 16'd7);
        drain();

        // Maximum noises and variance saturation.
        write_reg(REG_PROCESS_NOISE, 32'hFFFF_FFFF);
        write_reg(REG_FIRST_NOISE, 32'hFFFF_FFFF);
        write_reg(REG_SECOND_NOISE, 32'hFFFF_FFFF);
        write_reg(REG_START_VAR, 32'hFFFF_FFFF);
        write_reg(REG_SAMPLE_SCALE, 32'd65535);
        queue_word(1'b1, 16'hFFFF, 16'hFFFF);
        queue_word(1'b0, 16'hFFFF, 16'h0001);
        queue_word(1'b0, 16'h1234, 16'h8765);
        drain();

        // Scale drop makes the quotient overflow; zero scale acts as one.
        write_reg(REG_SAMPLE_SCALE, 32'd1);
        queue_word(1'b0, 16'd5, 16'd9);
        drain();
        write_reg(REG_SAMPLE_SCALE, 32'd0);
        write_reg(REG_FIRST_NOISE, 32'd3);
        write_reg(REG_SECOND_NOISE, 32'd100000);
        queue_word(1'b0, 16'd77, 16'd65000);
        queue_word(1'b1, 16'd77, 16'd65000);
        drain();

        // Random phases with new register settings between them.
        for (int ph = 0; ph < 6; ph++) begin
            random_noise_regs();
            queue_random(ITEMS / 6);
            if (ph == 2) begin
                while (pending_words.size() > ITEMS / 12) @(posedge aclk);
                long_hold = 1'b1;
                repeat (2000) @(posedge aclk);
                long_hold = 1'b0;
            end
            drain();
        end

        $display("Checked %0d fused words from %0d sent, %0d of them reloads.",
                 words_checked, words_sent, reloads_sent);
        $display("Covered zero and maximum noises, zero and maximum scale,");
        $display("and a long output stall.");
        if (errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule
`default_nettype wire
